>>> rtl/core/bary_pkg.sv
package bary_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned DiffBits    = CoordBits + 1;
  localparam int unsigned DotBits     = 2 * DiffBits + 2;
  localparam int unsigned SplitLo     = DotBits / 2;
  localparam int unsigned SplitHi     = DotBits - SplitLo;
  localparam int unsigned ProdBits    = 2 * DotBits;
  localparam int unsigned NumBits     = ProdBits + 3;
  localparam int unsigned WeightBits  = 32;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned FrontStages = 7;

  // Dot product slots.
  localparam int unsigned DotD11 = 0;
  localparam int unsigned DotD22 = 1;
  localparam int unsigned DotD12 = 2;
  localparam int unsigned DotR1  = 3;
  localparam int unsigned DotR2  = 4;

  typedef struct packed {
    logic signed [CoordBits-1:0] a_x;
    logic signed [CoordBits-1:0] a_y;
    logic signed [CoordBits-1:0] a_z;
    logic signed [CoordBits-1:0] b_x;
    logic signed [CoordBits-1:0] b_y;
    logic signed [CoordBits-1:0] b_z;
    logic signed [CoordBits-1:0] c_x;
    logic signed [CoordBits-1:0] c_y;
    logic signed [CoordBits-1:0] c_z;
    logic signed [CoordBits-1:0] pt_x;
    logic signed [CoordBits-1:0] pt_y;
    logic signed [CoordBits-1:0] pt_z;
  } in_t;

  typedef struct packed {
    logic signed [WeightBits-1:0] weight_a;
    logic signed [WeightBits-1:0] weight_b;
    logic signed [WeightBits-1:0] weight_c;
    logic                         degenerate;
  } out_t;

  // Determinant and numerators handed from the front end to the divider.
  typedef struct packed {
    logic signed [NumBits-1:0] det;
    logic signed [NumBits-1:0] na;
    logic signed [NumBits-1:0] nb;
    logic signed [NumBits-1:0] nc;
    logic                      degen;
  } num_t;

endpackage

>>> rtl/core/bary_front.sv
module bary_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  input  bary_pkg::in_t  in_i,
  output logic           push_o,
  input  logic           full_i,
  output bary_pkg::num_t num_o
);
  import bary_pkg::*;

  logic [FrontStages-1:0] v_q;
  logic adv;

  logic signed [CoordBits-1:0] av[3], bv[3], cv[3], pv[3];
  logic signed [DiffBits-1:0] q1_q[3], q2_q[3], r_q[3];
  logic signed [2*DiffBits-1:0] pp_q[5][3];
  logic signed [DotBits-1:0] dot_q[5];
  logic signed [DotBits-1:0] mx[6], my[6];
  logic signed [2*SplitHi-1:0] hh_q[6];
  logic signed [SplitHi+SplitLo:0] hl_q[6], lh_q[6];
  logic [2*SplitLo-1:0] ll_q[6];
  logic signed [ProdBits-1:0] prod_q[6];
  logic signed [NumBits-1:0] det_q, nb_q, nc_q;
  num_t num_q;

  // The whole front pipeline freezes only when its last stage cannot enter the queue.
  assign adv     = !(v_q[FrontStages-1] && full_i);
  assign stall_o = !adv;
  assign push_o  = v_q[FrontStages-1] && !full_i;
  assign num_o   = num_q;

  always_comb begin
    av[0] = in_i.a_x;  av[1] = in_i.a_y;  av[2] = in_i.a_z;
    bv[0] = in_i.b_x;  bv[1] = in_i.b_y;  bv[2] = in_i.b_z;
    cv[0] = in_i.c_x;  cv[1] = in_i.c_y;  cv[2] = in_i.c_z;
    pv[0] = in_i.pt_x; pv[1] = in_i.pt_y; pv[2] = in_i.pt_z;
  end

  always_comb begin
    mx[0] = dot_q[DotD11]; my[0] = dot_q[DotD22];
    mx[1] = dot_q[DotD12]; my[1] = dot_q[DotD12];
    mx[2] = dot_q[DotD22]; my[2] = dot_q[DotR1];
    mx[3] = dot_q[DotD12]; my[3] = dot_q[DotR2];
    mx[4] = dot_q[DotD11]; my[4] = dot_q[DotR2];
    mx[5] = dot_q[DotD12]; my[5] = dot_q[DotR1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[FrontStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        q1_q[k] <= DiffBits'(bv[k]) - DiffBits'(av[k]);
        q2_q[k] <= DiffBits'(cv[k]) - DiffBits'(av[k]);
        r_q[k]  <= DiffBits'(pv[k]) - DiffBits'(av[k]);
        pp_q[DotD11][k] <= (2*DiffBits)'(q1_q[k]) * (2*DiffBits)'(q1_q[k]);
        pp_q[DotD22][k] <= (2*DiffBits)'(q2_q[k]) * (2*DiffBits)'(q2_q[k]);
        pp_q[DotD12][k] <= (2*DiffBits)'(q1_q[k]) * (2*DiffBits)'(q2_q[k]);
        pp_q[DotR1][k]  <= (2*DiffBits)'(r_q[k]) * (2*DiffBits)'(q1_q[k]);
        pp_q[DotR2][k]  <= (2*DiffBits)'(r_q[k]) * (2*DiffBits)'(q2_q[k]);
      end
      for (int j = 0; j < 5; j++) begin
        dot_q[j] <= DotBits'(pp_q[j][0]) + DotBits'(pp_q[j][1]) + DotBits'(pp_q[j][2]);
      end
      // Wide products are split into four partial products and summed a stage later.
      for (int m = 0; m < 6; m++) begin
        hh_q[m] <= (2*SplitHi)'($signed(mx[m][DotBits-1:SplitLo]))
                 * (2*SplitHi)'($signed(my[m][DotBits-1:SplitLo]));
        hl_q[m] <= (SplitHi+SplitLo+1)'($signed(mx[m][DotBits-1:SplitLo]))
                 * (SplitHi+SplitLo+1)'($signed({1'b0, my[m][SplitLo-1:0]}));
        lh_q[m] <= (SplitHi+SplitLo+1)'($signed({1'b0, mx[m][SplitLo-1:0]}))
                 * (SplitHi+SplitLo+1)'($signed(my[m][DotBits-1:SplitLo]));
        ll_q[m] <= (2*SplitLo)'(mx[m][SplitLo-1:0]) * (2*SplitLo)'(my[m][SplitLo-1:0]);
        prod_q[m] <= (ProdBits'(hh_q[m]) <<< (2 * SplitLo))
                   + (ProdBits'(hl_q[m]) <<< SplitLo)
                   + (ProdBits'(lh_q[m]) <<< SplitLo)
                   + ProdBits'(ll_q[m]);
      end
      det_q <= NumBits'(prod_q[0]) - NumBits'(prod_q[1]);
      nb_q  <= NumBits'(prod_q[2]) - NumBits'(prod_q[3]);
      nc_q  <= NumBits'(prod_q[4]) - NumBits'(prod_q[5]);
      num_q.det   <= det_q;
      num_q.na    <= det_q - nb_q - nc_q;
      num_q.nb    <= nb_q;
      num_q.nc    <= nc_q;
      num_q.degen <= (det_q == '0);
    end
  end

`ifndef SYNTHESIS
  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[FrontStages-1] && full_i |=> v_q[FrontStages-1])
    else $error("front pipeline dropped an item while the queue was full");
`endif

endmodule

>>> rtl/core/bary_queue.sv
module bary_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bary_pkg::num_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bary_pkg::num_t data_o
);
  import bary_pkg::*;

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  num_t mem_q[QueueDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrBits+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrBits+1)'(QueueDepth))
    else $error("queue fill count out of range");
`endif

endmodule

>>> rtl/core/bary_div.sv
module bary_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           pop_o,
  input  bary_pkg::num_t num_i,
  output logic           valid_o,
  input  logic           stall_i,
  output bary_pkg::out_t out_o
);
  import bary_pkg::*;

  localparam int unsigned DivSteps = WeightBits;
  localparam int unsigned Stages   = DivSteps + 3;
  localparam int unsigned RemBits  = NumBits + WeightBits;

  logic [Stages-1:0] v_q;
  logic adv;

  logic signed [NumBits-1:0] numv[3];
  logic [NumBits-1:0] un_q[3], ud_q;
  logic neg0_q[3], dg0_q;

  logic [RemBits-1:0]    rem_q[DivSteps+1][3];
  logic [WeightBits-1:0] quo_q[DivSteps+1][3];
  logic                  ov_q[DivSteps+1][3];
  logic                  ng_q[DivSteps+1][3];
  logic [NumBits-1:0]    dd_q[DivSteps+1];
  logic                  dg_q[DivSteps+1];

  out_t out_q;

  function automatic logic [WeightBits-1:0] sat_weight(input logic [WeightBits-1:0] quo,
                                                       input logic ovf, input logic neg);
    logic [WeightBits-1:0] min_mag;
    logic [WeightBits-1:0] res;
    min_mag = {1'b1, {(WeightBits-1){1'b0}}};
    if (neg) begin
      if (ovf || (quo > min_mag)) res = min_mag;
      else res = -quo;
    end else begin
      if (ovf || quo[WeightBits-1]) res = {1'b0, {(WeightBits-1){1'b1}}};
      else res = quo;
    end
    return res;
  endfunction

  assign adv     = !v_q[Stages-1] || !stall_i;
  assign pop_o   = valid_i && adv;
  assign valid_o = v_q[Stages-1];
  assign out_o   = out_q;

  always_comb begin
    numv[0] = num_i.na;
    numv[1] = num_i.nb;
    numv[2] = num_i.nc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Stages-2:0], valid_i};
    end
  end

  // Magnitudes and quotient signs, then the range check and the initial remainder.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        un_q[k]   <= numv[k][NumBits-1] ? NumBits'(-numv[k]) : NumBits'(numv[k]);
        neg0_q[k] <= numv[k][NumBits-1] ^ num_i.det[NumBits-1];
      end
      ud_q  <= num_i.det[NumBits-1] ? NumBits'(-num_i.det) : NumBits'(num_i.det);
      dg0_q <= num_i.degen;
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= RemBits'(un_q[k]) << FRAC_BITS;
        quo_q[0][k] <= '0;
        ov_q[0][k]  <= (RemBits'(un_q[k]) << FRAC_BITS) >= (RemBits'(ud_q) << WeightBits);
        ng_q[0][k]  <= neg0_q[k];
      end
      dd_q[0] <= ud_q;
      dg_q[0] <= dg0_q;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s <= DivSteps; s++) begin : g_step
    localparam int unsigned Bit = DivSteps - s;
    logic [RemBits-1:0] dsh;
    logic               ge[3];

    assign dsh = RemBits'(dd_q[s-1]) << Bit;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        ge[k] = rem_q[s-1][k] >= dsh;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int k = 0; k < 3; k++) begin
          rem_q[s][k] <= ge[k] ? (rem_q[s-1][k] - dsh) : rem_q[s-1][k];
          quo_q[s][k] <= quo_q[s-1][k] | (ge[k] ? (WeightBits'(1) << Bit) : '0);
          ov_q[s][k]  <= ov_q[s-1][k];
          ng_q[s][k]  <= ng_q[s-1][k];
        end
        dd_q[s] <= dd_q[s-1];
        dg_q[s] <= dg_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dg_q[DivSteps]) begin
        out_q.weight_a   <= '0;
        out_q.weight_b   <= '0;
        out_q.weight_c   <= '0;
        out_q.degenerate <= 1'b1;
      end else begin
        out_q.weight_a   <= sat_weight(quo_q[DivSteps][0], ov_q[DivSteps][0], ng_q[DivSteps][0]);
        out_q.weight_b   <= sat_weight(quo_q[DivSteps][1], ov_q[DivSteps][1], ng_q[DivSteps][1]);
        out_q.weight_c   <= sat_weight(quo_q[DivSteps][2], ov_q[DivSteps][2], ng_q[DivSteps][2]);
        out_q.degenerate <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.degenerate |->
      (out_o.weight_a == '0) && (out_o.weight_b == '0) && (out_o.weight_c == '0))
    else $error("degenerate result carries nonzero weights");
`endif

endmodule

>>> rtl/core/triangle_barycentric_weights_top.sv
// Barycentric weights of a point against a 3D triangle, signed fixed point.
// Input channel: in_valid_i / in_stall_o carry one in_data_i item per transfer
// (vertices A, B, C and point P as signed integers). Output channel:
// out_valid_o / out_stall_i carry one out_data_o result per input item, in order
// (weights of A, B, C in Q(32-FRAC_BITS).FRAC_BITS, saturated, and a degenerate flag
// that is set with all weights zero when the Gram determinant is zero).
// Throughput is one item per cycle while out_stall_i is low. An item passes
// through 7 front stages (differences, dot products, split 36x36 products,
// determinant and numerators), the queue, and 35 divider stages (sign split,
// range check, 32 one-bit restoring steps, saturating output register).
// A 4-entry queue sits between the front end and the divider. When out_stall_i
// holds on a result, the divider freezes, the queue fills, and in_stall_o rises only
// once the last front stage finds the queue full; in_stall_o comes from registers.
// Reset clears all valid bits and queue pointers; no item is in flight after it.
module triangle_barycentric_weights_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bary_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bary_pkg::out_t out_data_o
);
  import bary_pkg::*;

  logic push, full, pop, empty;
  num_t front_num, queue_num;

  bary_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .in_i    (in_data_i),
    .push_o  (push),
    .full_i  (full),
    .num_o   (front_num)
  );

  bary_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_num),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (queue_num)
  );

  bary_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!empty),
    .pop_o   (pop),
    .num_i   (queue_num),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .out_o   (out_data_o)
  );

endmodule
